### rtl/motor_speed_pid_loop_macros.svh
// Assertion macros shared by the motor speed loop RTL
`ifndef MOTOR_SPEED_PID_LOOP_MACROS_SVH
`define MOTOR_SPEED_PID_LOOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MSP_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/msp_pkg.sv
// Shared types and constants of the motor speed loop
package msp_pkg;

  // Shared multiplier operand and product widths
  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 17;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Shared divider dividend and divisor widths
  localparam int unsigned DivNW = 55;
  localparam int unsigned DivDW = 48;

  // ms per minute, scales ticks per ms to rpm
  localparam logic [MulBW-1:0] MsPerMin = 17'd60000;
  // full PWM duty
  localparam logic [MulBW-1:0] DutyFull = 17'd255;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_COUNTS_PER_REV,
    REG_MAX_RPM,
    REG_UPDATE_PERIOD,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_OUT_MIN,
    REG_OUT_MAX
  } cfg_reg_e;

  // Input item kinds
  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // Multiplier request, operands taken as signed
  typedef struct packed {
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  // Divider request
  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/msp_mul.sv
// Shared signed multiplier with registered product
module msp_mul import msp_pkg::*; (
  input  logic                    clk_i,
  input  mul_req_t                req_i,
  output logic signed [MulPW-1:0] prod_o
);

  logic signed [MulPW-1:0] prod_q;

  // one product per cycle, read the cycle after the request
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(req_i.a) * $signed(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

### rtl/msp_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module msp_div import msp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output div_stat_t        stat_o,
  output logic [DivNW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivNW + 1);

  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DivDW-1:0] rem_q;
  logic [DivDW-1:0] rem_d;
  logic [DivDW-1:0] dvs_q;
  logic [DivNW-1:0] quo_q;
  logic [DivNW-1:0] quo_d;
  logic [DivDW:0]   rem_sh;
  logic [DivDW:0]   rem_sub;
  logic             fits;

  // one shift-and-subtract step; dividend bits leave the top of quo_q,
  // quotient bits enter at the bottom
  always_comb begin
    rem_sh  = {rem_q, quo_q[DivNW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_d   = fits ? rem_sub[DivDW-1:0] : rem_sh[DivDW-1:0];
    quo_d   = {quo_q[DivNW-2:0], fits};
  end

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

### rtl/motor_speed_pid_loop.sv
// Motor speed loop top level: tick counter, speed measurement, PID and PWM drive
//
//  channel | dir | handshake                     | contents
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | op in tuser; now_ms, target_rpm in tdata
//  m_axis  | out | m_axis_tvalid / m_axis_tready | duty, reverse, measured_rpm, taken
//  cfg     | in  | cfg_we_i                      | register index and write data
//
// An encoder edge is taken without leaving idle, and edges may arrive back to back.
// A control step runs one division, two when the speed is re-measured, on the shared
// one-bit-per-cycle divider (55 steps per division).
// Reset loads the register defaults and clears all loop state; no clearing pass.
// One result waits in the output register while the next item is accepted; a
// finished step holds there until that register frees up.
`include "motor_speed_pid_loop_macros.svh"

module motor_speed_pid_loop import msp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [31:0] now_ms, [55:32] target_rpm
  input  logic        s_axis_tuser,   // [0] op
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] duty, [8] reverse, [40:9] measured_rpm,
                                      // [41] measurement_taken, [47:42] zero
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MEAS_DEN,
    ST_MEAS_DIVS,
    ST_MEAS_WAIT,
    ST_ERR,
    ST_SUM,
    ST_P_ERR,
    ST_D_ERR,
    ST_I_LO,
    ST_I_HI,
    ST_ACC_END,
    ST_CLAMP,
    ST_DRV_MUL,
    ST_DRV_DIVS,
    ST_DRV_WAIT,
    ST_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [15:0]        cpr_q;
  logic [15:0]        mr_q;
  logic [9:0]         period_q;
  logic signed [15:0] gp_q;
  logic signed [15:0] gi_q;
  logic signed [15:0] gd_q;
  logic signed [23:0] omin_q;
  logic signed [23:0] omax_q;

  // loop state
  logic [31:0]        tick_q;
  logic [31:0]        tick_meas_q;
  logic [31:0]        meas_time_q;
  logic signed [31:0] speed_q;
  logic signed [47:0] sum_q;
  logic signed [31:0] last_err_q;
  logic signed [8:0]  drive_q;

  // per-step working registers
  logic [31:0]        now_q;
  logic signed [23:0] target_q;
  logic [31:0]        dt_q;
  logic               dneg_q;
  logic               taken_q;
  logic [54:0]        num_q;
  logic signed [31:0] err_q;
  logic signed [32:0] deriv_q;
  logic signed [63:0] acc_q;
  logic signed [23:0] pid_q;
  logic [7:0]         duty_q;
  logic               rev_q;

  // output register
  logic               m_valid_q;
  logic [47:0]        m_data_q;

  // shared units
  mul_req_t                mul_req;
  logic signed [MulPW-1:0] prod;
  div_req_t                div_req;
  div_stat_t               div_stat;
  logic [DivNW-1:0]        quot;

  // combinational helpers
  logic [31:0]        dt;
  logic [31:0]        delta;
  logic [31:0]        dmag;
  logic [15:0]        cpr_eff;
  logic [15:0]        mr_eff;
  logic signed [32:0] diff;
  logic signed [31:0] err_new;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_new;
  logic signed [32:0] deriv_new;
  logic signed [63:0] prod_ext;
  logic signed [63:0] prod_hi;
  logic signed [55:0] pid_full;
  logic signed [55:0] omin_ext;
  logic signed [55:0] omax_ext;
  logic signed [23:0] pid_new;
  logic [23:0]        pid_abs;
  logic signed [31:0] speed_new;
  logic [7:0]         mag_new;
  logic               in_acc;
  logic               out_free;
  logic               out_load;

  msp_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  msp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_OUT) && out_free;

  // measurement terms
  always_comb begin
    dt      = now_q - meas_time_q;
    delta   = tick_q - tick_meas_q;
    dmag    = delta[31] ? (32'd0 - delta) : delta;
    cpr_eff = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
    mr_eff  = (mr_q == 16'd0) ? 16'd1 : mr_q;
  end

  // speed from quotient, saturated to 32 bit signed
  always_comb begin
    if (dneg_q) begin
      speed_new = (quot >= 55'h8000_0000) ? 32'sh8000_0000 : -$signed(quot[31:0]);
    end else begin
      speed_new = (quot > 55'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quot[31:0]);
    end
    mag_new = (quot > 55'd255) ? 8'd255 : quot[7:0];
  end

  // error, integral and derivative terms
  always_comb begin
    diff = {{9{target_q[23]}}, target_q} - {speed_q[31], speed_q};
    if (diff[32] != diff[31]) begin
      err_new = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_new = diff[31:0];
    end
    sum_wide = {sum_q[47], sum_q} + {{17{err_q[31]}}, err_q};
    if (target_q == 24'sd0 && err_q == 32'sd0) begin
      sum_new = '0;
    end else if (sum_wide[48] != sum_wide[47]) begin
      sum_new = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sum_new = sum_wide[47:0];
    end
    deriv_new = {err_q[31], err_q} - {last_err_q[31], last_err_q};
  end

  // accumulator terms and output clamp
  always_comb begin
    prod_ext = {{(64 - MulPW){prod[MulPW-1]}}, prod};
    prod_hi  = {prod[39:0], 24'd0};
    pid_full = acc_q[63:8];
    omin_ext = {{32{omin_q[23]}}, omin_q};
    omax_ext = {{32{omax_q[23]}}, omax_q};
    if (pid_full < omin_ext) begin
      pid_new = omin_q;
    end else if (pid_full > omax_ext) begin
      pid_new = omax_q;
    end else begin
      pid_new = pid_full[23:0];
    end
    pid_abs = pid_q[23] ? (24'd0 - pid_q) : pid_q;
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      ST_CHECK: begin
        mul_req.a = {1'b0, dmag};
        mul_req.b = MsPerMin;
      end
      ST_MEAS_DEN: begin
        mul_req.a = {1'b0, dt_q};
        mul_req.b = {1'b0, cpr_eff};
      end
      ST_P_ERR: begin
        mul_req.a = {err_q[31], err_q};
        mul_req.b = {gp_q[15], gp_q};
      end
      ST_D_ERR: begin
        mul_req.a = deriv_q;
        mul_req.b = {gd_q[15], gd_q};
      end
      ST_I_LO: begin
        mul_req.a = {9'd0, sum_q[23:0]};
        mul_req.b = {gi_q[15], gi_q};
      end
      ST_I_HI: begin
        mul_req.a = {{9{sum_q[47]}}, sum_q[47:24]};
        mul_req.b = {gi_q[15], gi_q};
      end
      ST_DRV_MUL: begin
        mul_req.a = {9'd0, pid_abs};
        mul_req.b = DutyFull;
      end
      default: mul_req = '0;
    endcase
  end

  // divider start and operands
  always_comb begin
    div_req = '0;
    unique case (state_q)
      ST_MEAS_DIVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_q;
        div_req.divisor  = prod[47:0];
      end
      ST_DRV_DIVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {24'd0, prod[30:0]};
        div_req.divisor  = {24'd0, mr_eff, 8'd0};
      end
      default: div_req = '0;
    endcase
  end

  // sequencer, configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cpr_q       <= 16'd1000;
      mr_q        <= 16'd100;
      period_q    <= 10'd50;
      gp_q        <= 16'sd256;
      gi_q        <= '0;
      gd_q        <= '0;
      omin_q      <= 24'sh80_0000;
      omax_q      <= 24'sh7F_FFFF;
      tick_q      <= '0;
      tick_meas_q <= '0;
      meas_time_q <= '0;
      speed_q     <= '0;
      sum_q       <= '0;
      last_err_q  <= '0;
      drive_q     <= '0;
      now_q       <= '0;
      target_q    <= '0;
      dt_q        <= '0;
      dneg_q      <= 1'b0;
      taken_q     <= 1'b0;
      num_q       <= '0;
      err_q       <= '0;
      deriv_q     <= '0;
      acc_q       <= '0;
      pid_q       <= '0;
      duty_q      <= '0;
      rev_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_COUNTS_PER_REV: cpr_q    <= cfg_data_i[15:0];
          REG_MAX_RPM:        mr_q     <= cfg_data_i[15:0];
          REG_UPDATE_PERIOD:  period_q <= cfg_data_i[9:0];
          REG_GAIN_P:         gp_q     <= cfg_data_i[15:0];
          REG_GAIN_I:         gi_q     <= cfg_data_i[15:0];
          REG_GAIN_D:         gd_q     <= cfg_data_i[15:0];
          REG_OUT_MIN:        omin_q   <= cfg_data_i;
          REG_OUT_MAX:        omax_q   <= cfg_data_i;
        endcase
      end

      // output register drains unless a new result loads in the same cycle
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (op_e'(s_axis_tuser) == OP_STEP) begin
              now_q    <= s_axis_tdata[31:0];
              target_q <= s_axis_tdata[55:32];
              taken_q  <= 1'b0;
              state_q  <= ST_CHECK;
            end else if (drive_q > 9'sd0) begin
              tick_q <= tick_q + 32'd1;
            end else if (drive_q < 9'sd0) begin
              tick_q <= tick_q - 32'd1;
            end
          end
        end
        ST_CHECK: begin
          if (dt > {22'd0, period_q}) begin
            dt_q        <= dt;
            dneg_q      <= delta[31];
            meas_time_q <= now_q;
            tick_meas_q <= tick_q;
            taken_q     <= 1'b1;
            state_q     <= ST_MEAS_DEN;
          end else begin
            state_q <= ST_ERR;
          end
        end
        ST_MEAS_DEN: begin
          num_q   <= {prod[46:0], 8'd0};
          state_q <= ST_MEAS_DIVS;
        end
        ST_MEAS_DIVS: begin
          state_q <= ST_MEAS_WAIT;
        end
        ST_MEAS_WAIT: begin
          if (div_stat.done) begin
            speed_q <= speed_new;
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_q   <= err_new;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sum_q      <= sum_new;
          deriv_q    <= deriv_new;
          last_err_q <= err_q;
          state_q    <= ST_P_ERR;
        end
        ST_P_ERR: begin
          state_q <= ST_D_ERR;
        end
        ST_D_ERR: begin
          acc_q   <= prod_ext;
          state_q <= ST_I_LO;
        end
        ST_I_LO: begin
          acc_q   <= acc_q + prod_ext;
          state_q <= ST_I_HI;
        end
        ST_I_HI: begin
          acc_q   <= acc_q + prod_ext;
          state_q <= ST_ACC_END;
        end
        ST_ACC_END: begin
          acc_q   <= acc_q + prod_hi;
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          pid_q   <= pid_new;
          state_q <= ST_DRV_MUL;
        end
        ST_DRV_MUL: begin
          state_q <= ST_DRV_DIVS;
        end
        ST_DRV_DIVS: begin
          state_q <= ST_DRV_WAIT;
        end
        ST_DRV_WAIT: begin
          if (div_stat.done) begin
            duty_q <= mag_new;
            // a zero magnitude counts as stopped, not reverse
            rev_q  <= pid_q[23] && (mag_new != 8'd0);
            if (pid_q[23]) begin
              drive_q <= 9'sd0 - $signed({1'b0, mag_new});
            end else begin
              drive_q <= $signed({1'b0, mag_new});
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {6'd0, taken_q, speed_q, rev_q, duty_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks on the sequencer
  `MSP_ASSERT(a_div_start_idle, clk_i, rst_ni, div_req.start, !div_stat.busy, "divider started while busy")
  `MSP_ASSERT(a_div_done_wait, clk_i, rst_ni, div_stat.done, (state_q == ST_MEAS_WAIT) || (state_q == ST_DRV_WAIT), "divider result with no one waiting")
  `MSP_ASSERT(a_out_load_free, clk_i, rst_ni, out_load, (!m_axis_tvalid || m_axis_tready), "result overwrites a pending one")
  `MSP_ASSERT_NEXT(a_step_blocks, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "control step did not block the input")
  `MSP_ASSERT(a_drive_range, clk_i, rst_ni, 1'b1, drive_q != 9'sh100, "drive outside -255 to 255")

endmodule
